// ===== src/stfs_pkg.sv =====
// stfs_pkg: shared constants and codes for the sorted-table floor search.
// No dependencies; imported by sorted_table_floor_search_top.
`timescale 1ns / 1ps
`default_nettype none
package stfs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage
`default_nettype wire

// ===== src/stfs_ram.sv =====
// stfs_ram: generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module stfs_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/sorted_table_floor_search_top.sv =====
// sorted_table_floor_search_top: table of signed entries with a floor-search query.
// Depends on stfs_pkg and stfs_ram.
//
// Flow: clear and append finish without leaving idle; busy stays low, so they may come back
// to back. A query on an empty table returns out_valid the next cycle. Otherwise a query goes
// through a setup state, the search state once per binary-search probe (at most
// ceil(log2(entry count)) probes, 10 for a full table), a final state that reads the last
// candidate, and a back state when the floor is the entry just below it. busy drops as the
// result is registered, so the next item can be accepted while the result is shown. The
// single read port of the entry RAM limits the search to one probe per cycle.
// Reset (rst_n low, synchronous) empties the table and returns to idle. RAM contents are
// not cleared; only entries below the count are ever read. Results are a one-cycle strobe;
// the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_floor_search_top
  import stfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [DATA_W-1:0] in_value,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_found_value,
  output logic                   out_below_all,
  output logic                   out_table_empty
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,   // lo/hi loaded, issue first probe (or read lo if lo == hi)
    S_SEARCH,  // probe data back, narrow range
    S_FINAL,   // entry at lo back
    S_BACK     // entry at lo-1 back
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [ADDR_W-1:0] hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] found_r, found_nxt;
  logic              below_r, below_nxt;
  logic              empty_r, empty_nxt;

  // RAM port signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  // Search step helpers
  logic              probe_le;   // probed entry <= key (signed)
  logic [ADDR_W-1:0] step_lo, step_hi;
  logic [ADDR_W:0]   step_sum, setup_sum;

  stfs_ram #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found_value = found_r;
  assign out_below_all   = below_r;
  assign out_table_empty = empty_r;

  assign probe_le  = ($signed(rd_data) <= $signed(key_r));
  // mid < hi, so mid+1 never wraps
  assign step_lo   = probe_le ? (mid_r + ADDR_W'(1)) : lo_r;
  assign step_hi   = probe_le ? hi_r : mid_r;
  assign step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
  assign setup_sum = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    found_nxt     = found_r;
    below_nxt     = below_r;
    empty_nxt     = empty_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = in_value;
    rd_addr       = lo_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (action_t'(in_action))
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_APPEND: begin
              // full table: append dropped
              if (count_r < CNT_W'(TABLE_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_QUERY: begin
              key_nxt = in_value;
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                found_nxt     = '0;
                below_nxt     = 1'b0;
                empty_nxt     = 1'b1;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = ADDR_W'(count_r - CNT_W'(1));
                state_nxt = S_SETUP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SETUP: begin
        if (lo_r < hi_r) begin
          mid_nxt   = setup_sum[ADDR_W:1];
          rd_addr   = setup_sum[ADDR_W:1];
          state_nxt = S_SEARCH;
        end else begin
          rd_addr   = lo_r;
          state_nxt = S_FINAL;
        end
      end

      S_SEARCH: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        if (step_lo < step_hi) begin
          mid_nxt = step_sum[ADDR_W:1];
          rd_addr = step_sum[ADDR_W:1];
        end else begin
          rd_addr   = step_lo;
          state_nxt = S_FINAL;
        end
      end

      S_FINAL: begin
        if (probe_le || lo_r == '0) begin
          out_valid_nxt = 1'b1;
          found_nxt     = rd_data;
          below_nxt     = !probe_le;
          empty_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          rd_addr   = lo_r - ADDR_W'(1);
          state_nxt = S_BACK;
        end
      end

      S_BACK: begin
        out_valid_nxt = 1'b1;
        found_nxt     = rd_data;
        below_nxt     = 1'b0;
        empty_nxt     = 1'b0;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    below_r <= below_nxt;
    empty_r <= empty_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire
